FILE: hw/rtl/arp_cache_with_ttl_aging_unit_macros.svh
// Assertion helpers shared by the cache controller and datapath.
// Both expect signals named clk and rst_n in the using module.
`ifndef ARP_CACHE_WITH_TTL_AGING_UNIT_MACROS_SVH
`define ARP_CACHE_WITH_TTL_AGING_UNIT_MACROS_SVH

// Same-cycle implication.
`define ARPC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define ARPC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hw/rtl/arpc_pkg.sv
`timescale 1ns / 1ps

package arpc_pkg;

  localparam int IP_W      = 32;
  localparam int MAC_W     = 48;
  localparam int TTL_W     = 8;
  localparam int MAX_TTL_W = 7;
  localparam int TICKS_W   = 16;
  localparam int CFG_W     = 16;
  localparam int ENTRY_W   = IP_W + MAC_W + TTL_W;

  localparam logic [1:0] FUNC_LOOKUP = 2'd0;
  localparam logic [1:0] FUNC_REPLY  = 2'd1;
  localparam logic [1:0] FUNC_TICK   = 2'd2;

  localparam logic CFG_MAX_TTL       = 1'b0;
  localparam logic CFG_TICKS_PER_AGE = 1'b1;

  localparam logic [MAX_TTL_W-1:0] MAX_TTL_RST   = 7'd20;
  localparam logic [TICKS_W-1:0]   TICKS_RST     = 16'd600;
  localparam logic signed [TTL_W-1:0] TTL_EMPTY  = -8'sd2;

  typedef struct packed {
    logic [1:0]       func;
    logic [IP_W-1:0]  ip_address;
    logic [MAC_W-1:0] mac_address;
  } in_item_t;

  typedef struct packed {
    logic             hit;
    logic [MAC_W-1:0] found_mac;
    logic             request_needed;
  } out_item_t;

  typedef struct packed {
    logic start;
    logic rd_en;
    logic eval;
    logic fill;
    logic resp;
  } dp_cmd_t;

  typedef struct packed {
    logic hit;
    logic age_now;
    logic out_free;
  } dp_sts_t;

endpackage

FILE: hw/rtl/arpc_ram.sv
`timescale 1ns / 1ps

module arpc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8
) (
  input  logic                                   clk,
  input  logic                                   wr_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                       wr_data,
  input  logic                                   rd_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                       rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

FILE: hw/rtl/arpc_ctrl.sv
`timescale 1ns / 1ps
`include "arp_cache_with_ttl_aging_unit_macros.svh"

module arpc_ctrl #(
  parameter int TABLE_ENTRIES = 8
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  input  logic [1:0]             in_func,
  output logic                   in_ready,
  output arpc_pkg::dp_cmd_t      cmd,
  output logic [((TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1)-1:0] rd_addr,
  output logic [((TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1)-1:0] eval_addr,
  input  arpc_pkg::dp_sts_t      sts
);

  localparam int AW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam logic [AW-1:0] TOP_IDX = AW'(TABLE_ENTRIES - 1);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_FILL = 2'd2;
  localparam logic [1:0] ST_RESP = 2'd3;

  logic [1:0]    state_r, state_nxt;
  logic [1:0]    op_r, op_nxt;
  logic [AW-1:0] idx_r, idx_nxt;
  logic [AW-1:0] pidx_r, pidx_nxt;
  logic          issue_r, issue_nxt;
  logic          pend_r, pend_nxt;

  assign in_ready  = (state_r == ST_IDLE);
  assign rd_addr   = idx_r;
  assign eval_addr = pidx_r;

  always_comb begin
    state_nxt = state_r;
    op_nxt    = op_r;
    idx_nxt   = idx_r;
    pidx_nxt  = pidx_r;
    issue_nxt = issue_r;
    pend_nxt  = pend_r;
    cmd       = '0;
    unique case (state_r)
      ST_IDLE: begin
        cmd.start = in_valid;
        if (in_valid) begin
          op_nxt    = in_func;
          idx_nxt   = TOP_IDX;
          issue_nxt = 1'b1;
          pend_nxt  = 1'b0;
          if (in_func == arpc_pkg::FUNC_LOOKUP || in_func == arpc_pkg::FUNC_REPLY ||
              (in_func == arpc_pkg::FUNC_TICK && sts.age_now)) begin
            state_nxt = ST_SCAN;
          end else begin
            state_nxt = ST_RESP;
          end
        end
      end
      ST_SCAN: begin
        cmd.rd_en = issue_r;
        cmd.eval  = pend_r;
        // one read in flight: entry data returns in the cycle after its address
        pend_nxt  = issue_r;
        pidx_nxt  = idx_r;
        if (issue_r) begin
          if (idx_r == '0) begin
            issue_nxt = 1'b0;
          end else begin
            idx_nxt = idx_r - 1'b1;
          end
        end
        if (pend_r && sts.hit) begin
          state_nxt = ST_RESP;
        end else if (!issue_r && !pend_r) begin
          state_nxt = (op_r == arpc_pkg::FUNC_REPLY) ? ST_FILL : ST_RESP;
        end
      end
      ST_FILL: begin
        cmd.fill  = 1'b1;
        state_nxt = ST_RESP;
      end
      ST_RESP: begin
        cmd.resp = sts.out_free;
        if (sts.out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      op_r    <= arpc_pkg::FUNC_LOOKUP;
      idx_r   <= '0;
      pidx_r  <= '0;
      issue_r <= 1'b0;
      pend_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      op_r    <= op_nxt;
      idx_r   <= idx_nxt;
      pidx_r  <= pidx_nxt;
      issue_r <= issue_nxt;
      pend_r  <= pend_nxt;
    end
  end

  `ARPC_ASSERT_NEXT(a_accept_leaves_idle, cmd.start, state_r != ST_IDLE, "item accepted but controller stayed idle")
  `ARPC_ASSERT_NOW(a_fill_only_reply, state_r == ST_FILL, op_r == arpc_pkg::FUNC_REPLY, "fill outside a reply")
  `ARPC_ASSERT_NOW(a_eval_after_read, state_r == ST_SCAN && pend_r, $past(issue_r), "entry evaluated without a read")

endmodule

FILE: hw/rtl/arpc_dp.sv
`timescale 1ns / 1ps
`include "arp_cache_with_ttl_aging_unit_macros.svh"

module arpc_dp #(
  parameter int TABLE_ENTRIES = 8
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  arpc_pkg::in_item_t                in_data,
  input  arpc_pkg::dp_cmd_t                 cmd,
  input  logic [((TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1)-1:0] rd_addr,
  input  logic [((TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1)-1:0] eval_addr,
  output arpc_pkg::dp_sts_t                 sts,
  output logic                              out_valid,
  input  logic                              out_ready,
  output arpc_pkg::out_item_t               out_data,
  input  logic                              cfg_we,
  input  logic                              cfg_index,
  input  logic [arpc_pkg::CFG_W-1:0]        cfg_data
);

  localparam int AW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam logic [AW-1:0] TOP_IDX = AW'(TABLE_ENTRIES - 1);

  logic [arpc_pkg::MAX_TTL_W-1:0]     max_ttl_r;
  logic [arpc_pkg::TICKS_W-1:0]       ticks_r;
  logic [arpc_pkg::TICKS_W-1:0]       count_r;
  logic [TABLE_ENTRIES-1:0]           valid_r;
  logic [1:0]                         op_r;
  logic [arpc_pkg::IP_W-1:0]          ip_r;
  logic [arpc_pkg::MAC_W-1:0]         mac_r;
  logic signed [arpc_pkg::TTL_W-1:0]  low_r;
  logic [AW-1:0]                      pick_r;
  logic                               hit_r;
  logic [arpc_pkg::MAC_W-1:0]         hit_mac_r;
  logic                               out_valid_r;
  arpc_pkg::out_item_t                out_data_r;

  logic [arpc_pkg::ENTRY_W-1:0]       rd_data;
  logic [arpc_pkg::ENTRY_W-1:0]       wr_data;
  logic [AW-1:0]                      wr_addr;
  logic                               wr_en;
  logic [arpc_pkg::IP_W-1:0]          ent_ip;
  logic [arpc_pkg::MAC_W-1:0]         ent_mac;
  logic signed [arpc_pkg::TTL_W-1:0]  ent_ttl;
  logic signed [arpc_pkg::TTL_W-1:0]  max_ttl_s;
  logic                               live;
  logic                               look_hit;
  logic                               age_wr;
  logic                               low_upd;
  logic [2:0]                         wr_src;

  assign ent_ip    = rd_data[arpc_pkg::ENTRY_W-1 -: arpc_pkg::IP_W];
  assign ent_mac   = rd_data[arpc_pkg::TTL_W +: arpc_pkg::MAC_W];
  // a never-written entry reads as empty
  assign ent_ttl   = valid_r[eval_addr] ? signed'(rd_data[arpc_pkg::TTL_W-1:0])
                                        : arpc_pkg::TTL_EMPTY;
  assign max_ttl_s = signed'({1'b0, max_ttl_r});
  assign live      = (ent_ttl > 8'sd0);

  assign look_hit = cmd.eval && (op_r == arpc_pkg::FUNC_LOOKUP) && (ent_ip == ip_r) && live;
  assign age_wr   = cmd.eval && (op_r == arpc_pkg::FUNC_TICK) && live;
  assign low_upd  = cmd.eval && (op_r == arpc_pkg::FUNC_REPLY) && (ent_ttl < low_r);
  assign wr_src   = {cmd.fill, look_hit, age_wr};

  always_comb begin
    wr_en   = cmd.fill || look_hit || age_wr;
    wr_addr = eval_addr;
    wr_data = {ent_ip, ent_mac, ent_ttl - 8'sd1};
    if (cmd.fill) begin
      wr_addr = pick_r;
      wr_data = {ip_r, mac_r, max_ttl_s};
    end else if (look_hit) begin
      wr_data = {ent_ip, ent_mac, max_ttl_s};
    end
  end

  arpc_ram #(
    .WIDTH (arpc_pkg::ENTRY_W),
    .DEPTH (TABLE_ENTRIES)
  ) u_entries (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (cmd.rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  assign sts.hit      = look_hit;
  assign sts.age_now  = (count_r == 16'd1);
  assign sts.out_free = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_ttl_r   <= arpc_pkg::MAX_TTL_RST;
      ticks_r     <= arpc_pkg::TICKS_RST;
      count_r     <= arpc_pkg::TICKS_RST;
      valid_r     <= '0;
      op_r        <= arpc_pkg::FUNC_LOOKUP;
      hit_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == arpc_pkg::CFG_MAX_TTL) begin
          max_ttl_r <= cfg_data[arpc_pkg::MAX_TTL_W-1:0];
        end else begin
          ticks_r <= cfg_data;
        end
      end
      if (wr_en) begin
        valid_r[wr_addr] <= 1'b1;
      end
      if (cmd.start) begin
        op_r  <= in_data.func;
        hit_r <= 1'b0;
        if (in_data.func == arpc_pkg::FUNC_TICK) begin
          // reload on reaching zero; zero reload wraps on the next tick
          count_r <= (count_r == 16'd1) ? ticks_r : count_r - 16'd1;
        end
      end else if (look_hit) begin
        hit_r <= 1'b1;
      end
      if (cmd.resp) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      ip_r   <= in_data.ip_address;
      mac_r  <= in_data.mac_address;
      low_r  <= max_ttl_s;
      pick_r <= TOP_IDX;
    end else if (low_upd) begin
      low_r  <= ent_ttl;
      pick_r <= eval_addr;
    end
    if (look_hit) begin
      hit_mac_r <= ent_mac;
    end
    if (cmd.resp) begin
      out_data_r.hit            <= hit_r;
      out_data_r.found_mac      <= hit_r ? hit_mac_r : '0;
      out_data_r.request_needed <= (op_r == arpc_pkg::FUNC_LOOKUP) && !hit_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  `ARPC_ASSERT_NOW(a_one_writer, wr_en, $onehot0(wr_src), "two sources write the table at once")
  `ARPC_ASSERT_NOW(a_resp_has_room, cmd.resp, !out_valid_r || out_ready, "result overwrites an untaken item")

endmodule

FILE: hw/rtl/arp_cache_with_ttl_aging_unit.sv
`timescale 1ns / 1ps
// ARP cache with TTL aging.
// Input channel (in_valid/in_ready/in_data): one item per operation: lookup,
// reply insert or timer tick. Result channel (out_valid/out_ready/out_data):
// exactly one item per input item, in order. Configuration writes (cfg_we,
// cfg_index, cfg_data) set max_ttl and ticks_per_age and take effect at once;
// issue them only while the block is idle.
// Operation: a lookup or reply scans the table from the top entry down, one
// entry per cycle through the entry RAM's single read port. A lookup hit stops
// the scan early, a lookup miss scans every entry, and a reply adds a table
// write in its fill state. A tick that triggers an aging pass costs the same
// scan; any other tick goes straight to the result stage. One item is in work
// at a time; in_ready is high while the controller is idle, even if the last
// result still waits, so a new item is taken only once the last one is done.
// When the receiver stalls, a finished result holds in the output register and
// the next item stalls only at its own result stage.
// Reset: all entries read as empty (TTL -2), registers return to max_ttl 20
// and ticks_per_age 600, and the aging counter loads 600. No clearing pass.
module arp_cache_with_ttl_aging_unit #(
  parameter int TABLE_ENTRIES = 8
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  arpc_pkg::in_item_t          in_data,
  output logic                        out_valid,
  input  logic                        out_ready,
  output arpc_pkg::out_item_t         out_data,
  input  logic                        cfg_we,
  input  logic                        cfg_index,
  input  logic [arpc_pkg::CFG_W-1:0]  cfg_data
);

  localparam int AW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;

  arpc_pkg::dp_cmd_t cmd;
  arpc_pkg::dp_sts_t sts;
  logic [AW-1:0]     rd_addr;
  logic [AW-1:0]     eval_addr;

  arpc_ctrl #(
    .TABLE_ENTRIES (TABLE_ENTRIES)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_func   (in_data.func),
    .in_ready  (in_ready),
    .cmd       (cmd),
    .rd_addr   (rd_addr),
    .eval_addr (eval_addr),
    .sts       (sts)
  );

  arpc_dp #(
    .TABLE_ENTRIES (TABLE_ENTRIES)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cmd       (cmd),
    .rd_addr   (rd_addr),
    .eval_addr (eval_addr),
    .sts       (sts),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

endmodule

FILE: bench/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

  localparam int ENTRIES = 8;
  localparam int POOL = 12;
  localparam logic [1:0] FUNC_SPARE = 2'd3;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  arpc_pkg::in_item_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  arpc_pkg::out_item_t out_data;
  logic cfg_we = 1'b0;
  logic cfg_index = 1'b0;
  logic [arpc_pkg::CFG_W-1:0] cfg_data = '0;

  arp_cache_with_ttl_aging_unit #(
    .TABLE_ENTRIES(ENTRIES)
  ) dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data(out_data),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Cache copy kept by the bench
  logic [arpc_pkg::IP_W-1:0] tbl_ip [ENTRIES];
  logic [arpc_pkg::MAC_W-1:0] tbl_mac [ENTRIES];
  logic signed [arpc_pkg::TTL_W-1:0] tbl_ttl [ENTRIES];
  logic [arpc_pkg::TICKS_W-1:0] age_left;
  logic [arpc_pkg::MAX_TTL_W-1:0] cur_max_ttl;
  logic [arpc_pkg::TICKS_W-1:0] cur_ticks;

  arpc_pkg::in_item_t op_queue[$];
  arpc_pkg::out_item_t due_results[$];
  logic [arpc_pkg::IP_W-1:0] ip_pool [POOL];
  arpc_pkg::out_item_t result_want;
  int n_errors = 0;
  int phase_ticks = 0;
  int send_gap = 0;
  int stall_left = 0;
  bit send_calm = 1'b0;
  bit recv_calm = 1'b0;

  function automatic arpc_pkg::out_item_t predict_cache_op(arpc_pkg::in_item_t op);
    arpc_pkg::out_item_t res;
    int i;
    int lowest;
    int pick;
    bit found;
    res = '0;
    found = 1'b0;
    case (op.func)
      arpc_pkg::FUNC_LOOKUP: begin
        for (i = ENTRIES - 1; i >= 0; i--) begin
          if (!found && tbl_ip[i] == op.ip_address && tbl_ttl[i] > 0) begin
            found = 1'b1;
            tbl_ttl[i] = $signed({1'b0, cur_max_ttl});
            res.hit = 1'b1;
            res.found_mac = tbl_mac[i];
          end
        end
        res.request_needed = !found;
      end
      arpc_pkg::FUNC_REPLY: begin
        // strict compare from the top: ties keep the higher index
        lowest = int'(cur_max_ttl);
        pick = ENTRIES - 1;
        for (i = ENTRIES - 1; i >= 0; i--) begin
          if (int'(tbl_ttl[i]) < lowest) begin
            lowest = int'(tbl_ttl[i]);
            pick = i;
          end
        end
        tbl_ttl[pick] = $signed({1'b0, cur_max_ttl});
        tbl_ip[pick] = op.ip_address;
        tbl_mac[pick] = op.mac_address;
      end
      arpc_pkg::FUNC_TICK: begin
        age_left = age_left - 1'b1;
        if (age_left == '0) begin
          age_left = cur_ticks;
          for (i = 0; i < ENTRIES; i++) begin
            if (tbl_ttl[i] > 0) tbl_ttl[i] = tbl_ttl[i] - 8'sd1;
          end
        end
      end
      default: begin
      end
    endcase
    return res;
  endfunction

  function automatic int pick_pause(bit calm);
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [arpc_pkg::MAC_W-1:0] rand_mac();
    logic [63:0] w;
    int r;
    r = $urandom_range(0, 99);
    w = {$urandom, $urandom};
    if (r < 5) w = '0;
    else if (r < 10) w = '1;
    return w[arpc_pkg::MAC_W-1:0];
  endfunction

  task automatic flag_field(string name, logic [arpc_pkg::MAC_W-1:0] exp_v,
                            logic [arpc_pkg::MAC_W-1:0] act_v);
    n_errors++;
    $display("%0t: %s expected %h, got %h", $time, name, exp_v, act_v);
  endtask

  task automatic push_op(logic [1:0] f, logic [arpc_pkg::IP_W-1:0] ip,
                         logic [arpc_pkg::MAC_W-1:0] mac);
    arpc_pkg::in_item_t op;
    op.func = f;
    op.ip_address = ip;
    op.mac_address = mac;
    op_queue.push_back(op);
  endtask

  task automatic gen_random(int tick_pct);
    int r;
    logic [1:0] f;
    logic [arpc_pkg::IP_W-1:0] ip;
    r = $urandom_range(0, 99);
    if (r < tick_pct) f = arpc_pkg::FUNC_TICK;
    else if (r < tick_pct + 3) f = FUNC_SPARE;
    else if ($urandom_range(0, 99) < 55) f = arpc_pkg::FUNC_LOOKUP;
    else f = arpc_pkg::FUNC_REPLY;
    // mostly reuse a small address set so lookups find live entries
    if ($urandom_range(0, 99) < 80) ip = ip_pool[$urandom_range(0, POOL - 1)];
    else ip = $urandom;
    if (f == arpc_pkg::FUNC_TICK) phase_ticks++;
    push_op(f, ip, rand_mac());
  endtask

  task automatic wait_drained();
    do @(negedge clk);
    while (op_queue.size() != 0 || in_valid || due_results.size() != 0);
  endtask

  task automatic set_reg(logic idx, logic [arpc_pkg::CFG_W-1:0] data);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    if (idx == arpc_pkg::CFG_MAX_TTL) cur_max_ttl = data[arpc_pkg::MAX_TTL_W-1:0];
    else cur_ticks = data[arpc_pkg::TICKS_W-1:0];
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // Reconfigure while idle, then queue random items until count items and min_ticks ticks are queued.
  task automatic run_phase(int ttl, int ticks, int count, int tick_pct, int min_ticks);
    logic [arpc_pkg::CFG_W-1:0] d;
    int i;
    int n;
    wait_drained();
    d = arpc_pkg::CFG_W'($urandom);
    d[arpc_pkg::MAX_TTL_W-1:0] = arpc_pkg::MAX_TTL_W'(ttl);
    set_reg(arpc_pkg::CFG_MAX_TTL, d);
    set_reg(arpc_pkg::CFG_TICKS_PER_AGE, arpc_pkg::CFG_W'(ticks));
    for (i = 0; i < POOL; i++) ip_pool[i] = $urandom;
    ip_pool[0] = '0;
    ip_pool[1] = '1;
    phase_ticks = 0;
    n = 0;
    while (n < count || phase_ticks < min_ticks) begin
      gen_random(tick_pct);
      n++;
    end
  endtask

  // Driver: predict on acceptance, then present the next item after a random gap
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) due_results.push_back(predict_cache_op(in_data));
      if ($urandom_range(0, 63) == 0) send_calm = !send_calm;
      if (!in_valid || in_ready) begin
        if (send_gap > 0) begin
          send_gap--;
          in_valid <= 1'b0;
        end else if (op_queue.size() != 0) begin
          in_valid <= 1'b1;
          in_data <= op_queue.pop_front();
          send_gap = pick_pause(send_calm);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: compare each result with the oldest prediction, stall at random
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (due_results.size() == 0) begin
          n_errors++;
          $display("%0t: unexpected result %h", $time, out_data);
        end else begin
          result_want = due_results.pop_front();
          if (out_data.hit !== result_want.hit)
            flag_field("hit", arpc_pkg::MAC_W'(result_want.hit),
                       arpc_pkg::MAC_W'(out_data.hit));
          if (out_data.found_mac !== result_want.found_mac)
            flag_field("found_mac", result_want.found_mac, out_data.found_mac);
          if (out_data.request_needed !== result_want.request_needed)
            flag_field("request_needed", arpc_pkg::MAC_W'(result_want.request_needed),
                       arpc_pkg::MAC_W'(out_data.request_needed));
        end
      end
      if ($urandom_range(0, 63) == 0) recv_calm = !recv_calm;
      if (stall_left > 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
        if ($urandom_range(0, 3) == 0) stall_left = pick_pause(recv_calm);
      end
    end
  end

  initial begin
    for (int i = 0; i < ENTRIES; i++) begin
      tbl_ip[i] = '0;
      tbl_mac[i] = '0;
      tbl_ttl[i] = arpc_pkg::TTL_EMPTY;
    end
    cur_max_ttl = arpc_pkg::MAX_TTL_RST;
    cur_ticks = arpc_pkg::TICKS_RST;
    age_left = arpc_pkg::TICKS_RST;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // Fill every entry before any lookup; empty entries go top down
    push_op(arpc_pkg::FUNC_REPLY, 32'h0000_0000, 48'h0000_0000_0000);
    push_op(arpc_pkg::FUNC_REPLY, 32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF);
    push_op(arpc_pkg::FUNC_REPLY, 32'h0A00_0001, 48'h0000_1111_2222);
    push_op(arpc_pkg::FUNC_REPLY, 32'h0A00_0001, 48'h0000_3333_4444);
    push_op(arpc_pkg::FUNC_REPLY, 32'hC0A8_0001, 48'hA5A5_5A5A_F00F);
    push_op(arpc_pkg::FUNC_REPLY, 32'h7F00_0001, 48'h8000_0000_0001);
    push_op(arpc_pkg::FUNC_REPLY, 32'h8000_0000, 48'h7FFF_FFFF_FFFE);
    push_op(arpc_pkg::FUNC_REPLY, 32'h0000_0001, 48'h0123_4567_89AB);
    push_op(arpc_pkg::FUNC_LOOKUP, 32'h0000_0000, 48'hFFFF_FFFF_FFFF);
    push_op(arpc_pkg::FUNC_LOOKUP, 32'hFFFF_FFFF, 48'h0000_0000_0000);
    // duplicate address: the higher entry wins
    push_op(arpc_pkg::FUNC_LOOKUP, 32'h0A00_0001, 48'h0);
    push_op(arpc_pkg::FUNC_LOOKUP, 32'h1234_5678, 48'h0);
    push_op(FUNC_SPARE, 32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF);
    push_op(arpc_pkg::FUNC_LOOKUP, 32'hC0A8_0001, 48'h0);
    push_op(arpc_pkg::FUNC_TICK, 32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF);
    push_op(arpc_pkg::FUNC_LOOKUP, 32'h8000_0000, 48'h0);
    // every entry at max: the top entry is replaced
    push_op(arpc_pkg::FUNC_REPLY, 32'hDEAD_BEEF, 48'hCAFE_0000_BABE);
    push_op(arpc_pkg::FUNC_LOOKUP, 32'h0000_0000, 48'h0);
    push_op(arpc_pkg::FUNC_LOOKUP, 32'hDEAD_BEEF, 48'h0);
    push_op(arpc_pkg::FUNC_LOOKUP, 32'h0000_0001, 48'h0);
    push_op(arpc_pkg::FUNC_TICK, 32'h0, 48'h0);

    // drain the countdown loaded at reset so short aging periods take hold
    run_phase(20, 1, 0, 95, 600);
    run_phase(127, 2, 45, 20, 0);
    run_phase(1, 1, 45, 25, 0);
    run_phase(0, 3, 30, 20, 0);
    run_phase(5, 0, 40, 25, 0);
    run_phase(127, 65535, 40, 20, 0);

    wait_drained();
    repeat (30) @(posedge clk);
    if (n_errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  initial begin
    #3000000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
